@@ sv/tksel_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksel_pkg
// shared types, widths and helpers for the top-k token selector
// ----------------------------------------------------------------------------
package tksel_pkg;

  localparam int MAX_TOKENS = 64;
  localparam int MAX_EMBED  = 4096;
  localparam int TOK_W      = $clog2(MAX_TOKENS);      // token index width
  localparam int CNT_W      = TOK_W + 1;               // token count width
  localparam int ELEM_W     = 16;
  localparam int SQ_W       = 31;                      // square of a q4.12 value
  localparam int ENERGY_W   = 44;
  localparam int ECNT_W     = 12;                      // element counter width
  localparam int DIM_W      = 13;
  localparam int RATIO_W    = 17;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};

  // mode register codes
  localparam logic [MODE_W-1:0] MODE_KEEP_ALL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_THIN     = 2'd1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EMBED_DIM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_K     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PROTECT   = 3'd4;

  typedef enum logic [3:0] {
    S_LOAD,
    S_DRAIN,
    S_SETUP,
    S_CHECK,
    S_RD_I,
    S_LAT_I,
    S_SCAN,
    S_TAIL,
    S_DECIDE,
    S_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // input beats may be taken
    logic setup;    // work out keep count, seed keep mask
    logic rd_i;     // read energy of candidate i
    logic lat_i;    // capture candidate energy, clear rank
    logic scan;     // read energy of competitor j
    logic decide;   // keep candidate i if its rank is low enough
    logic emit;     // drain kept indices to the output register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_acc;   // beat closing the set was taken
    logic thin;       // l2 thinning mode
    logic i_done;     // all candidates ranked
    logic j_last;     // competitor scan at final token
    logic emit_done;  // final result loaded into output register
  } dp_status_t;

  // lowest set bit of a token mask
  function automatic logic [TOK_W-1:0] low_index(input logic [MAX_TOKENS-1:0] v);
    logic [TOK_W-1:0] r;
    r = '0;
    for (int k = MAX_TOKENS - 1; k >= 0; k--) begin
      if (v[k]) begin
        r = TOK_W'(k);
      end
    end
    return r;
  endfunction

endpackage

@@ sv/tksel_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksel_ctrl
// sequencer for load, ranking and emission phases
// ----------------------------------------------------------------------------
module tksel_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tksel_pkg::dp_status_t st,
  output tksel_pkg::ctrl_cmd_t  cmd
);

  tksel_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tksel_pkg::S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      tksel_pkg::S_LOAD: begin
        cmd.load = 1'b1;
        if (st.last_acc) begin
          state_nxt = tksel_pkg::S_DRAIN;
        end
      end
      // closing beat still in the accumulate stage
      tksel_pkg::S_DRAIN: begin
        state_nxt = tksel_pkg::S_SETUP;
      end
      tksel_pkg::S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = tksel_pkg::S_CHECK;
      end
      tksel_pkg::S_CHECK: begin
        if (!st.thin || st.i_done) begin
          state_nxt = tksel_pkg::S_EMIT;
        end else begin
          state_nxt = tksel_pkg::S_RD_I;
        end
      end
      tksel_pkg::S_RD_I: begin
        cmd.rd_i  = 1'b1;
        state_nxt = tksel_pkg::S_LAT_I;
      end
      tksel_pkg::S_LAT_I: begin
        cmd.lat_i = 1'b1;
        state_nxt = tksel_pkg::S_SCAN;
      end
      tksel_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.j_last) begin
          state_nxt = tksel_pkg::S_TAIL;
        end
      end
      // last compare lands
      tksel_pkg::S_TAIL: begin
        state_nxt = tksel_pkg::S_DECIDE;
      end
      tksel_pkg::S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = tksel_pkg::S_CHECK;
      end
      tksel_pkg::S_EMIT: begin
        cmd.emit = 1'b1;
        if (st.emit_done) begin
          state_nxt = tksel_pkg::S_LOAD;
        end
      end
      default: begin
        state_nxt = tksel_pkg::S_LOAD;
      end
    endcase
  end

endmodule

@@ sv/tksel_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksel_dp
// energy accumulation, energy store, rank counting and result register
// ----------------------------------------------------------------------------
module tksel_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  tksel_pkg::ctrl_cmd_t                 cmd,
  output tksel_pkg::dp_status_t                st,
  // input beats
  input  logic                                 in_valid,
  input  logic signed [tksel_pkg::ELEM_W-1:0]  in_elem_value,
  input  logic                                 in_last_of_set,
  // configuration writes
  input  logic                                 cfg_we,
  input  logic [tksel_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tksel_pkg::CFG_DATA_W-1:0]     cfg_data,
  // result beats
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic [tksel_pkg::TOK_W-1:0]          out_token_index,
  output logic                                 out_last_result,
  output logic                                 out_no_selection
);

  localparam int TOK_W    = tksel_pkg::TOK_W;
  localparam int CNT_W    = tksel_pkg::CNT_W;
  localparam int ENERGY_W = tksel_pkg::ENERGY_W;
  localparam int SQ_W     = tksel_pkg::SQ_W;
  localparam int ECNT_W   = tksel_pkg::ECNT_W;
  localparam int DIM_W    = tksel_pkg::DIM_W;
  localparam int RATIO_W  = tksel_pkg::RATIO_W;
  localparam int MODE_W   = tksel_pkg::MODE_W;
  localparam int NTOK     = tksel_pkg::MAX_TOKENS;
  localparam int PROD_W   = CNT_W + RATIO_W;
  localparam int KEEP_W   = PROD_W - 16;

  // config registers
  logic [MODE_W-1:0]  mode_r;
  logic [DIM_W-1:0]   embed_dim_r;
  logic [CNT_W-1:0]   top_k_r;
  logic [RATIO_W-1:0] ratio_r;
  logic [CNT_W-1:0]   protect_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= tksel_pkg::MODE_KEEP_ALL;
      embed_dim_r <= DIM_W'(1);
      top_k_r     <= '0;
      ratio_r     <= '0;
      protect_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tksel_pkg::CFG_MODE:      mode_r      <= cfg_data[MODE_W-1:0];
        tksel_pkg::CFG_EMBED_DIM: embed_dim_r <= cfg_data[DIM_W-1:0];
        tksel_pkg::CFG_TOP_K:     top_k_r     <= cfg_data[CNT_W-1:0];
        tksel_pkg::CFG_RATIO:     ratio_r     <= cfg_data[RATIO_W-1:0];
        tksel_pkg::CFG_PROTECT:   protect_r   <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: square
  logic               in_acc;
  logic signed [2*tksel_pkg::ELEM_W-1:0] sq_full;
  logic [SQ_W-1:0]    sq_r;
  logic               sq_v_r;
  logic               sq_last_r;

  assign in_acc  = in_valid & cmd.load;
  assign sq_full = in_elem_value * in_elem_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r <= 1'b0;
    end else begin
      sq_v_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sq_r      <= sq_full[SQ_W-1:0];
      sq_last_r <= in_last_of_set;
    end
  end

  // stage 2: saturating accumulate, token close
  logic [ENERGY_W-1:0] acc_r;
  logic [ECNT_W-1:0]   elem_cnt_r;
  logic [CNT_W-1:0]    tok_cnt_r;
  logic [CNT_W-1:0]    n_r;
  logic [ENERGY_W:0]   sum;
  logic [ENERGY_W-1:0] sum_sat;
  logic [ECNT_W-1:0]   elem_inc;
  logic [DIM_W-1:0]    dim_eff;
  logic                close_tok;
  logic                mem_we;
  logic [CNT_W-1:0]    tok_after;

  always_comb begin
    if (embed_dim_r == '0) begin
      dim_eff = DIM_W'(1);
    end else if (embed_dim_r > DIM_W'(tksel_pkg::MAX_EMBED)) begin
      dim_eff = DIM_W'(tksel_pkg::MAX_EMBED);
    end else begin
      dim_eff = embed_dim_r;
    end
  end

  assign sum       = {1'b0, acc_r} + (ENERGY_W + 1)'(sq_r);
  assign sum_sat   = sum[ENERGY_W] ? tksel_pkg::ENERGY_MAX : sum[ENERGY_W-1:0];
  assign elem_inc  = elem_cnt_r + ECNT_W'(1);
  assign close_tok = (elem_inc == '0) || ({1'b0, elem_inc} >= dim_eff) || sq_last_r;
  assign mem_we    = sq_v_r && close_tok && !tok_cnt_r[CNT_W-1];
  assign tok_after = tok_cnt_r[CNT_W-1] ? tok_cnt_r : tok_cnt_r + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r      <= '0;
      elem_cnt_r <= '0;
      tok_cnt_r  <= '0;
    end else if (sq_v_r) begin
      if (close_tok) begin
        acc_r      <= '0;
        elem_cnt_r <= '0;
        tok_cnt_r  <= sq_last_r ? '0 : tok_after;
      end else begin
        acc_r      <= sum_sat;
        elem_cnt_r <= elem_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sq_v_r && sq_last_r) begin
      n_r <= tok_after;
    end
  end

  // energy store
  logic [ENERGY_W-1:0] energy_mem [NTOK];
  logic [ENERGY_W-1:0] rd_q;
  logic [CNT_W-1:0]    i_r;
  logic [CNT_W-1:0]    j_r;
  logic [TOK_W-1:0]    rd_addr;

  assign rd_addr = cmd.scan ? j_r[TOK_W-1:0] : i_r[TOK_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      energy_mem[tok_cnt_r[TOK_W-1:0]] <= sum_sat;
    end
    if (cmd.rd_i || cmd.scan) begin
      rd_q <= energy_mem[rd_addr];
    end
  end

  // setup: keep count and protected prefix
  logic [PROD_W-1:0]   prod;
  logic [KEEP_W-1:0]   keep;
  logic [KEEP_W-1:0]   to_sel_r;
  logic [CNT_W-1:0]    prot;
  logic [CNT_W-1:0]    prot_r;
  logic [CNT_W-1:0]    seed_lim;
  logic [NTOK-1:0]     mask_r;

  assign prod = PROD_W'(n_r) * PROD_W'(ratio_r);

  always_comb begin
    if (ratio_r != '0) begin
      keep = (prod[PROD_W-1:16] == '0) ? KEEP_W'(1) : prod[PROD_W-1:16];
    end else if (top_k_r != '0) begin
      keep = KEEP_W'((top_k_r < n_r) ? top_k_r : n_r);
    end else begin
      keep = KEEP_W'(n_r);
    end
  end

  assign prot     = (protect_r < n_r) ? protect_r : n_r;
  assign seed_lim = (mode_r == tksel_pkg::MODE_KEEP_ALL) ? n_r : prot;

  // ranking
  logic [ENERGY_W-1:0] ei_r;
  logic [CNT_W-1:0]    rank_r;
  logic                cmp_v_r;
  logic [CNT_W-1:0]    cmp_j_r;
  logic                beats;

  assign beats = cmp_v_r && (cmp_j_r != i_r) &&
                 ((rd_q > ei_r) || ((rd_q == ei_r) && (cmp_j_r < i_r)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_v_r <= 1'b0;
    end else begin
      cmp_v_r <= cmd.scan;
    end
  end

  always_ff @(posedge clk) begin
    cmp_j_r <= j_r;
    if (cmd.setup) begin
      to_sel_r <= (keep > KEEP_W'(protect_r)) ? keep - KEEP_W'(protect_r) : '0;
      prot_r   <= prot;
      i_r      <= prot;
    end
    if (cmd.rd_i) begin
      j_r <= prot_r;
    end
    if (cmd.scan) begin
      j_r <= j_r + CNT_W'(1);
    end
    if (cmd.lat_i) begin
      ei_r   <= rd_q;
      rank_r <= '0;
    end else if (beats) begin
      rank_r <= rank_r + CNT_W'(1);
    end
    if (cmd.decide) begin
      i_r <= i_r + CNT_W'(1);
    end
  end

  // emission
  logic              out_valid_r;
  logic [TOK_W-1:0]  out_idx_r;
  logic              out_last_r;
  logic              out_nosel_r;
  logic              out_free;
  logic              nosel;
  logic [TOK_W-1:0]  low_idx;
  logic [NTOK-1:0]   low_bit;
  logic              mask_last;
  logic              load_out;

  assign out_free  = !out_valid_r || !out_stall;
  assign nosel     = mode_r[MODE_W-1];
  assign low_idx   = tksel_pkg::low_index(mask_r);
  assign low_bit   = NTOK'(1) << low_idx;
  assign mask_last = (mask_r & ~low_bit) == '0;
  assign load_out  = cmd.emit && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else if (cmd.setup) begin
      for (int k = 0; k < NTOK; k++) begin
        mask_r[k] <= CNT_W'(k) < seed_lim;
      end
    end else if (cmd.decide) begin
      if ({1'b0, rank_r} < to_sel_r) begin
        mask_r[i_r[TOK_W-1:0]] <= 1'b1;
      end
    end else if (load_out) begin
      mask_r <= nosel ? '0 : (mask_r & ~low_bit);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_idx_r   <= nosel ? '0 : low_idx;
      out_last_r  <= nosel ? 1'b1 : mask_last;
      out_nosel_r <= nosel;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_token_index  = out_idx_r;
  assign out_last_result  = out_last_r;
  assign out_no_selection = out_nosel_r;

  assign st.last_acc  = in_acc && in_last_of_set;
  assign st.thin      = mode_r == tksel_pkg::MODE_THIN;
  assign st.i_done    = i_r == n_r;
  assign st.j_last    = j_r == n_r - CNT_W'(1);
  assign st.emit_done = load_out && (nosel || mask_last);

  // checks
  a_tok_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tok_cnt_r <= CNT_W'(NTOK))
    else $error("token count past capacity");

  a_mask_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && !nosel |-> mask_r != '0)
    else $error("emitting with empty keep mask");

  a_nosel_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_nosel_r |-> out_last_r)
    else $error("no-selection result not marked last");

  a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.decide |-> rank_r < n_r)
    else $error("rank exceeds token count");

endmodule

@@ sv/token_topk_l2_select.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// token_topk_l2_select
// streaming top-k token selection by squared l2 energy
// ----------------------------------------------------------------------------
// sequence: n*dim element beats (n tokens) at one per cycle, then close, set up
//   and check, then in thinning mode each unprotected token is ranked against
//   the other unprotected ones, then one result per cycle while out_stall is low
// throughput: one set at a time, input stalled from the closing beat until the
//   final result is loaded; ranking reads one competitor per cycle
// reset: synchronous active-low rst_n clears control, load counters, mask and config
// ----------------------------------------------------------------------------
module token_topk_l2_select (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // element beats
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [tksel_pkg::ELEM_W-1:0]  in_elem_value,
  input  logic                                 in_last_of_set,
  // kept index beats
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [tksel_pkg::TOK_W-1:0]          out_token_index,
  output logic                                 out_last_result,
  output logic                                 out_no_selection,
  // config writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tksel_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tksel_pkg::CFG_DATA_W-1:0]     cfg_data
);

  tksel_pkg::ctrl_cmd_t  cmd;
  tksel_pkg::dp_status_t st;

  // input is only taken while loading; the output register lets the
  // next set start loading while the final beat still waits
  assign in_stall  = !cmd.load;

  // config must be written only while idle; the block does not enforce this, so it is always taken
  assign cfg_ready = 1'b1;

  tksel_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .cmd   (cmd)
  );

  tksel_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .in_valid         (in_valid),
    .in_elem_value    (in_elem_value),
    .in_last_of_set   (in_last_of_set),
    .cfg_we           (cfg_valid & cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_token_index  (out_token_index),
    .out_last_result  (out_last_result),
    .out_no_selection (out_no_selection)
  );

endmodule
